/* rtl/core/dnslbl_pkg.sv */
// shared constants and types for the dns name label encoder
package dnslbl_pkg;

	localparam int LABEL_MAX_DEF = 63;
	localparam int LEN_W         = 7;
	localparam int Q_DEPTH       = 2;
	localparam int Q_AW          = 1;

	localparam logic [7:0] ASCII_TOP = 8'd127;
	localparam logic [7:0] SEPARATOR = 8'd46;
	localparam logic [7:0] TERM_CHAR = 8'd0;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_NONASCII = 2'd1;
	localparam logic [1:0] ST_EMPTY    = 2'd2;
	localparam logic [1:0] ST_TOOLONG  = 2'd3;

	localparam logic [1:0] CNT_NONE = 2'd0;
	localparam logic [1:0] CNT_ONE  = 2'd1;
	localparam logic [1:0] CNT_TWO  = 2'd2;

	typedef struct packed {
		logic             err;
		logic [1:0]       status;
		logic [LEN_W-1:0] len;
		logic             term;
		logic             slot;
	} cmd_t;

	typedef struct packed {
		logic valid;
		logic slot;
	} rel_t;

endpackage

/* rtl/core/dnslbl_ram.sv */
// generic single write port ram with registered read
module dnslbl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* rtl/core/dnslbl_fifo.sv */
// two entry command queue between front and back
module dnslbl_fifo (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  dnslbl_pkg::cmd_t   push_cmd,
	input  logic               pop,
	output logic               head_valid,
	output dnslbl_pkg::cmd_t   head_cmd,
	output logic               full
);

	dnslbl_pkg::cmd_t              mem_q [dnslbl_pkg::Q_DEPTH];
	logic [dnslbl_pkg::Q_AW-1:0]   wr_q;
	logic [dnslbl_pkg::Q_AW-1:0]   rd_q;
	logic [dnslbl_pkg::Q_AW:0]     cnt_q;

	assign head_valid = (cnt_q != '0);
	assign head_cmd   = mem_q[rd_q];
	assign full       = (cnt_q == (dnslbl_pkg::Q_AW+1)'(dnslbl_pkg::Q_DEPTH));

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

/* rtl/core/dnslbl_front.sv */
// front part: accepts name bytes, buffers labels, queues label and error words
module dnslbl_front #(
	parameter int LABEL_MAX = dnslbl_pkg::LABEL_MAX_DEF,
	parameter int HW        = 5
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [7:0]         char_byte,
	output logic               q_push,
	output dnslbl_pkg::cmd_t   q_cmd,
	input  logic               q_full,
	input  dnslbl_pkg::rel_t   rel,
	output logic               we_even,
	output logic               we_odd,
	output logic [HW:0]        waddr,
	output logic [7:0]         wdata
);

	localparam logic [dnslbl_pkg::LEN_W-1:0] LMAX = dnslbl_pkg::LEN_W'(LABEL_MAX);

	logic [dnslbl_pkg::LEN_W-1:0] len_q;
	logic                         slot_q;
	logic [1:0]                   busy_q;
	logic                         is_hi;
	logic                         is_close;
	logic                         acc;
	logic                         we;
	logic [dnslbl_pkg::LEN_W-1:0] half;

	assign is_hi    = (char_byte > dnslbl_pkg::ASCII_TOP);
	assign is_close = is_hi || (char_byte == dnslbl_pkg::TERM_CHAR) ||
	                  (char_byte == dnslbl_pkg::SEPARATOR);
	assign in_stall = busy_q[slot_q] || (q_full && is_close);
	assign acc      = in_valid && !in_stall;
	assign q_push   = acc && is_close;

	always_comb begin
		q_cmd.len  = len_q;
		q_cmd.term = (char_byte == dnslbl_pkg::TERM_CHAR);
		q_cmd.slot = slot_q;
		q_cmd.err  = 1'b1;
		if (is_hi) begin
			q_cmd.status = dnslbl_pkg::ST_NONASCII;
		end else if (len_q == '0) begin
			q_cmd.status = dnslbl_pkg::ST_EMPTY;
		end else if (len_q > LMAX) begin
			q_cmd.status = dnslbl_pkg::ST_TOOLONG;
		end else begin
			q_cmd.status = dnslbl_pkg::ST_OK;
			q_cmd.err    = 1'b0;
		end
	end

	assign we      = acc && !is_close && (len_q < LMAX);
	assign we_even = we && !len_q[0];
	assign we_odd  = we && len_q[0];
	assign half    = len_q >> 1;
	assign waddr   = {slot_q, half[HW-1:0]};
	assign wdata   = char_byte;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q  <= '0;
			slot_q <= 1'b0;
			busy_q <= '0;
		end else begin
			if (acc) begin
				if (is_close) begin
					len_q <= '0;
					if (!q_cmd.err) begin
						slot_q <= ~slot_q;
					end
				end else if (len_q <= LMAX) begin
					len_q <= len_q + 1'b1;
				end
			end
			if (q_push && !q_cmd.err) begin
				busy_q[slot_q] <= 1'b1;
			end
			if (rel.valid) begin
				busy_q[rel.slot] <= 1'b0;
			end
		end
	end

endmodule

/* rtl/core/dnslbl_back.sv */
// back part: drains queued words into results of up to two bytes
module dnslbl_back #(
	parameter int HW = 5
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_valid,
	input  dnslbl_pkg::cmd_t   q_cmd,
	output logic               q_pop,
	output dnslbl_pkg::rel_t   rel,
	output logic               re,
	output logic [HW:0]        raddr_even,
	output logic [HW:0]        raddr_odd,
	input  logic [7:0]         rdata_even,
	input  logic [7:0]         rdata_odd,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [7:0]         first_byte,
	output logic [7:0]         second_byte,
	output logic [1:0]         byte_count,
	output logic               run_last,
	output logic               name_end,
	output logic [1:0]         status
);

	logic [dnslbl_pkg::LEN_W-1:0] k_q;
	logic [dnslbl_pkg::LEN_W-1:0] km1;
	logic [7:0]                   total;
	logic [7:0]                   k2;
	logic [7:0]                   len8;
	logic                         last;
	logic                         two;
	logic                         issue;
	logic                         adv2;

	logic                         s2_valid_s2;
	logic [7:0]                   first_imm_s2;
	logic                         first_ram_s2;
	logic                         second_ram_s2;
	logic [1:0]                   count_s2;
	logic                         last_s2;
	logic                         end_s2;
	logic [1:0]                   status_s2;

	logic                         out_valid_q;
	logic [7:0]                   first_q;
	logic [7:0]                   second_q;
	logic [1:0]                   count_q;
	logic                         last_q;
	logic                         end_q;
	logic [1:0]                   status_q;

	assign len8  = {1'b0, q_cmd.len};
	assign total = len8 + 8'd1 + {7'd0, q_cmd.term};
	assign k2    = {k_q, 1'b0};
	assign last  = q_cmd.err || ((k2 + 8'd2) >= total);
	assign two   = (k2 + 8'd1) < total;
	assign km1   = k_q - 1'b1;

	assign adv2  = s2_valid_s2 && (!out_valid_q || !out_stall);
	assign issue = q_valid && (!s2_valid_s2 || adv2);
	assign q_pop = issue && last;

	assign rel.valid  = issue && last && !q_cmd.err;
	assign rel.slot   = q_cmd.slot;
	assign re         = issue && !q_cmd.err;
	assign raddr_even = {q_cmd.slot, k_q[HW-1:0]};
	assign raddr_odd  = {q_cmd.slot, km1[HW-1:0]};

	always_ff @(posedge clk) begin
		if (issue) begin
			first_imm_s2  <= (!q_cmd.err && k_q == '0) ? len8 : 8'd0;
			first_ram_s2  <= !q_cmd.err && (k_q != '0) && (k2 <= len8);
			second_ram_s2 <= !q_cmd.err && two && ((k2 + 8'd1) <= len8);
			count_s2      <= q_cmd.err ? dnslbl_pkg::CNT_NONE :
			                 (two ? dnslbl_pkg::CNT_TWO : dnslbl_pkg::CNT_ONE);
			last_s2       <= last;
			end_s2        <= last && (q_cmd.err || q_cmd.term);
			status_s2     <= q_cmd.status;
		end
		if (adv2) begin
			first_q  <= first_ram_s2 ? rdata_odd : first_imm_s2;
			second_q <= second_ram_s2 ? rdata_even : 8'd0;
			count_q  <= count_s2;
			last_q   <= last_s2;
			end_q    <= end_s2;
			status_q <= status_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q         <= '0;
			s2_valid_s2 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (issue) begin
				k_q <= last ? '0 : k_q + 1'b1;
			end
			if (issue) begin
				s2_valid_s2 <= 1'b1;
			end else if (adv2) begin
				s2_valid_s2 <= 1'b0;
			end
			if (adv2) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign first_byte  = first_q;
	assign second_byte = second_q;
	assign byte_count  = count_q;
	assign run_last    = last_q;
	assign name_end    = end_q;
	assign status      = status_q;

endmodule

/* rtl/core/dns_name_label_encoder_unit.sv */
// top level of the dns name label encoder
//
// input channel (in_valid, in_stall, char_byte): one ascii byte of a dotted
// name per word; a zero byte ends the name, a period separates labels.
// output channel (out_valid, out_stall, first_byte .. status): wire bytes,
// two per word: label length, label bytes, and the zero root byte after
// the last label. an error gives one word with status set and ends the name.
// ordinary bytes are taken one per cycle while the label slot being filled
// is free. a closing byte queues a label or error word; the back part then
// emits one result per cycle while the output is not stalled, reading an
// even and an odd byte bank in parallel. a queued word passes the queue,
// the ram read and the output register before its first result shows up.
// two label slots let the next label fill while the previous one drains;
// input stalls when the slot to be filled is still draining or when the
// two entry queue is full on a closing byte.
// a stalled output holds its word; the back part stops behind it.
// reset clears the label count, queue, slot flags and output valid; the
// label memory is not cleared, only bytes of the current label are read.
module dns_name_label_encoder_unit #(
	parameter int LABEL_MAX = dnslbl_pkg::LABEL_MAX_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] char_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] first_byte,
	output logic [7:0] second_byte,
	output logic [1:0] byte_count,
	output logic       run_last,
	output logic       name_end,
	output logic [1:0] status
);

	localparam int HALF_DEPTH = (LABEL_MAX + 1) / 2;
	localparam int HW         = (HALF_DEPTH > 1) ? $clog2(HALF_DEPTH) : 1;
	localparam int RAM_DEPTH  = 2 * (2 ** HW);

	logic               q_push;
	logic               q_pop;
	logic               q_full;
	logic               q_valid;
	dnslbl_pkg::cmd_t   q_in;
	dnslbl_pkg::cmd_t   q_head;
	dnslbl_pkg::rel_t   rel;
	logic               we_even;
	logic               we_odd;
	logic [HW:0]        waddr;
	logic [7:0]         wdata;
	logic               re;
	logic [HW:0]        raddr_even;
	logic [HW:0]        raddr_odd;
	logic [7:0]         rdata_even;
	logic [7:0]         rdata_odd;

	dnslbl_front #(
		.LABEL_MAX(LABEL_MAX),
		.HW(HW)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.char_byte(char_byte),
		.q_push(q_push),
		.q_cmd(q_in),
		.q_full(q_full),
		.rel(rel),
		.we_even(we_even),
		.we_odd(we_odd),
		.waddr(waddr),
		.wdata(wdata)
	);

	dnslbl_fifo u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(q_push),
		.push_cmd(q_in),
		.pop(q_pop),
		.head_valid(q_valid),
		.head_cmd(q_head),
		.full(q_full)
	);

	dnslbl_ram #(
		.WIDTH(8),
		.DEPTH(RAM_DEPTH)
	) u_ram_even (
		.clk(clk),
		.we(we_even),
		.waddr(waddr),
		.wdata(wdata),
		.re(re),
		.raddr(raddr_even),
		.rdata(rdata_even)
	);

	dnslbl_ram #(
		.WIDTH(8),
		.DEPTH(RAM_DEPTH)
	) u_ram_odd (
		.clk(clk),
		.we(we_odd),
		.waddr(waddr),
		.wdata(wdata),
		.re(re),
		.raddr(raddr_odd),
		.rdata(rdata_odd)
	);

	dnslbl_back #(
		.HW(HW)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_valid(q_valid),
		.q_cmd(q_head),
		.q_pop(q_pop),
		.rel(rel),
		.re(re),
		.raddr_even(raddr_even),
		.raddr_odd(raddr_odd),
		.rdata_even(rdata_even),
		.rdata_odd(rdata_odd),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.first_byte(first_byte),
		.second_byte(second_byte),
		.byte_count(byte_count),
		.run_last(run_last),
		.name_end(name_end),
		.status(status)
	);

endmodule

/* rtl/core/dnslbl_checker.sv */
// port level checks for the dns name label encoder
module dnslbl_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic [7:0] char_byte,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] first_byte,
	input logic [7:0] second_byte,
	input logic [1:0] byte_count,
	input logic       run_last,
	input logic       name_end,
	input logic [1:0] status
);

	// error words carry no bytes and end the name
	a_err_shape: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != dnslbl_pkg::ST_OK |->
		byte_count == dnslbl_pkg::CNT_NONE && run_last && name_end &&
		first_byte == 8'd0 && second_byte == 8'd0)
		else $error("error word malformed");

	// empty words only on errors
	a_ok_bytes: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == dnslbl_pkg::ST_OK |->
		byte_count == dnslbl_pkg::CNT_ONE || byte_count == dnslbl_pkg::CNT_TWO)
		else $error("ok word without bytes");

	a_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && name_end |-> run_last)
		else $error("name end without run last");

	a_single_pad: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && byte_count == dnslbl_pkg::CNT_ONE |-> second_byte == 8'd0)
		else $error("unused second byte not zero");

	// a single byte word closes its run
	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && byte_count == dnslbl_pkg::CNT_ONE |-> run_last)
		else $error("single byte word not last");

endmodule

bind dns_name_label_encoder_unit dnslbl_checker u_chk (.*);

/* test/testbench.sv */
// self-checking testbench for the dns name label encoder unit
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LABEL_MAX   = dnslbl_pkg::LABEL_MAX_DEF;
	localparam int NAME_BYTES  = 210;
	localparam int DRAIN_WAIT  = 20;
	localparam int STALL_LIMIT = 2000;

	typedef struct packed {
		logic [7:0] first_byte;
		logic [7:0] second_byte;
		logic [1:0] byte_count;
		logic       run_last;
		logic       name_end;
		logic [1:0] status;
	} wire_word_t;

	logic       clk;
	logic       arst_n;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [7:0] char_byte = '0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [7:0] first_byte;
	logic [7:0] second_byte;
	logic [1:0] byte_count;
	logic       run_last;
	logic       name_end;
	logic [1:0] status;

	logic [7:0] name_bytes[$];
	wire_word_t wire_words[$];
	logic [7:0] label_buf[0:LABEL_MAX-1];
	logic [6:0] label_len = '0;

	int bytes_queued;
	int bytes_taken;
	int words_checked;
	int labels_encoded;
	int errors_seen[4];
	int mismatches;
	int quiet_cycles;

	dns_name_label_encoder_unit #(
		.LABEL_MAX(LABEL_MAX)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.char_byte(char_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.first_byte(first_byte),
		.second_byte(second_byte),
		.byte_count(byte_count),
		.run_last(run_last),
		.name_end(name_end),
		.status(status)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// expected wire words for one name byte
	task automatic push_error(input logic [1:0] st);
		wire_word_t w;
		w = '{8'd0, 8'd0, dnslbl_pkg::CNT_NONE, 1'b1, 1'b1, st};
		wire_words.push_back(w);
		errors_seen[st]++;
		label_len = '0;
	endtask

	task automatic encode_name_byte(input logic [7:0] c);
		logic [7:0] wire_bytes[0:LABEL_MAX+1];
		wire_word_t w;
		int total;
		bit term;
		if (c > dnslbl_pkg::ASCII_TOP) begin
			push_error(dnslbl_pkg::ST_NONASCII);
		end else if (c != dnslbl_pkg::TERM_CHAR && c != dnslbl_pkg::SEPARATOR) begin
			if (label_len < LABEL_MAX)
				label_buf[label_len] = c;
			if (label_len <= LABEL_MAX)
				label_len++;
		end else if (label_len == 0) begin
			push_error(dnslbl_pkg::ST_EMPTY);
		end else if (label_len > LABEL_MAX) begin
			push_error(dnslbl_pkg::ST_TOOLONG);
		end else begin
			term = (c == dnslbl_pkg::TERM_CHAR);
			wire_bytes[0] = {1'b0, label_len};
			for (int i = 0; i < label_len; i++)
				wire_bytes[i + 1] = label_buf[i];
			total = label_len + 1;
			if (term) begin
				wire_bytes[total] = dnslbl_pkg::TERM_CHAR;
				total++;
			end
			for (int i = 0; i < total; i += 2) begin
				w.first_byte  = wire_bytes[i];
				w.second_byte = (i + 1 < total) ? wire_bytes[i + 1] : 8'd0;
				w.byte_count  = (i + 1 < total) ? dnslbl_pkg::CNT_TWO : dnslbl_pkg::CNT_ONE;
				w.run_last    = (i + 2 >= total);
				w.name_end    = (i + 2 >= total) && term;
				w.status      = dnslbl_pkg::ST_OK;
				wire_words.push_back(w);
			end
			labels_encoded++;
			label_len = '0;
		end
	endtask

	task automatic check_field(input string fname, input logic [7:0] want,
			input logic [7:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", fname, want, got);
			mismatches++;
		end
	endtask

	// stimulus helpers
	task automatic queue_byte(input logic [7:0] b);
		name_bytes.push_back(b);
		bytes_queued++;
	endtask

	task automatic queue_label(input int len);
		int c;
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(0, 99) < 3) begin
				c = $urandom_range(128, 255);
			end else begin
				c = $urandom_range(1, 126);
				if (c >= dnslbl_pkg::SEPARATOR)
					c++;
			end
			queue_byte(c[7:0]);
		end
	endtask

	function automatic int pick_label_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 5)
			return 0;
		if (r < 9)
			return $urandom_range(LABEL_MAX - 3, LABEL_MAX);
		if (r < 12)
			return $urandom_range(LABEL_MAX + 1, LABEL_MAX + 4);
		return $urandom_range(1, 10);
	endfunction

	task automatic queue_name();
		int labels;
		int closer;
		labels = $urandom_range(1, 4);
		for (int k = 0; k < labels; k++) begin
			queue_label(pick_label_len());
			closer = (k == labels - 1) ? int'(dnslbl_pkg::TERM_CHAR) :
				int'(dnslbl_pkg::SEPARATOR);
			if ($urandom_range(0, 99) < 2)
				closer = $urandom_range(128, 255);
			queue_byte(closer[7:0]);
		end
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid  <= 1'b0;
			char_byte <= '0;
		end else if (!in_valid || !in_stall) begin
			if (name_bytes.size() != 0 && ((bytes_taken >= 60 && bytes_taken < 130)
					|| $urandom_range(0, 99) >= 10)) begin
				in_valid  <= 1'b1;
				char_byte <= name_bytes.pop_front();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// monitor: check the output word first, then predict the input word
	always @(posedge clk or negedge arst_n) begin
		wire_word_t w;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				words_checked++;
				if (wire_words.size() == 0) begin
					$error("result word with nothing expected");
					mismatches++;
				end else begin
					w = wire_words.pop_front();
					check_field("first_byte", w.first_byte, first_byte);
					check_field("second_byte", w.second_byte, second_byte);
					check_field("byte_count", {6'd0, w.byte_count}, {6'd0, byte_count});
					check_field("run_last", {7'd0, w.run_last}, {7'd0, run_last});
					check_field("name_end", {7'd0, w.name_end}, {7'd0, name_end});
					check_field("status", {6'd0, w.status}, {6'd0, status});
				end
			end
			if (in_valid && !in_stall) begin
				bytes_taken++;
				encode_name_byte(char_byte);
			end
			out_stall <= !(words_checked >= 40 && words_checked < 100)
				&& $urandom_range(0, 99) < 10;
		end
	end

	// watchdog on cycles with no word moving on either side
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("timeout: no word moved for %0d cycles", STALL_LIMIT);
				$display("FAIL");
				$finish;
			end
		end
	end

	initial begin
		arst_n = 1'b0;

		// empty name, leading period
		queue_byte(dnslbl_pkg::TERM_CHAR);
		queue_byte(dnslbl_pkg::SEPARATOR);
		// two one-byte labels with extreme characters
		queue_byte(8'd1);
		queue_byte(dnslbl_pkg::SEPARATOR);
		queue_byte(8'd127);
		queue_byte(dnslbl_pkg::TERM_CHAR);
		// two periods in a row
		queue_byte(8'd120);
		queue_byte(dnslbl_pkg::SEPARATOR);
		queue_byte(dnslbl_pkg::SEPARATOR);
		// trailing period before the terminator
		queue_byte(8'd120);
		queue_byte(8'd121);
		queue_byte(dnslbl_pkg::SEPARATOR);
		queue_byte(dnslbl_pkg::TERM_CHAR);
		// non-ascii inside a label and at the start of a name
		queue_byte(8'd113);
		queue_byte(8'd255);
		queue_byte(8'd128);
		// odd and even wire lengths
		queue_byte(8'd97);
		queue_byte(8'd98);
		queue_byte(8'd99);
		queue_byte(dnslbl_pkg::TERM_CHAR);
		queue_byte(8'd97);
		queue_byte(8'd98);
		queue_byte(dnslbl_pkg::TERM_CHAR);

		// longest label, then one byte too long
		queue_label(LABEL_MAX);
		queue_byte(dnslbl_pkg::TERM_CHAR);
		queue_label(LABEL_MAX + 1);
		queue_byte(dnslbl_pkg::TERM_CHAR);
		while (bytes_queued < NAME_BYTES)
			queue_name();

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		while (name_bytes.size() != 0 || in_valid)
			@(posedge clk);
		while (wire_words.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		$display("sent %0d name bytes, checked %0d wire words, %0d labels encoded",
			bytes_taken, words_checked, labels_encoded);
		$display("errors covered: non-ascii %0d, empty label %0d, label too long %0d",
			errors_seen[dnslbl_pkg::ST_NONASCII], errors_seen[dnslbl_pkg::ST_EMPTY],
			errors_seen[dnslbl_pkg::ST_TOOLONG]);
		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

/* filelist.f */
rtl/core/dnslbl_pkg.sv
rtl/core/dnslbl_ram.sv
rtl/core/dnslbl_fifo.sv
rtl/core/dnslbl_front.sv
rtl/core/dnslbl_back.sv
rtl/core/dns_name_label_encoder_unit.sv
rtl/core/dnslbl_checker.sv
test/testbench.sv
